// ===== hdl/mfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfsd_pkg
// Shared types, constants and the bitrate table for the frame sync block.
// ----------------------------------------------------------------------------
package mfsd_pkg;

  // width of byte position and file size arithmetic
  localparam int unsigned SIZE_BITS = 32;
  // remain / (kbps * 128) is done as (remain >> 7) / kbps
  localparam int unsigned BPS_SHIFT = 7;
  localparam int unsigned DIV_BITS  = SIZE_BITS - BPS_SHIFT;
  localparam int unsigned CNT_W     = $clog2(DIV_BITS + 1);
  localparam int unsigned KBPS_W    = 9;

  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned BPS_W    = 16;
  localparam int unsigned DUR_W    = 21;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam logic [7:0] SECOND_MASK  = 8'hFE;
  localparam logic [7:0] SECOND_MATCH = 8'hFA;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SYNC  = 2'd1,
    STATUS_BAD_RATE = 2'd2
  } status_e;

  // one classified event handed from front to back
  typedef struct packed {
    status_e              status;
    logic [SIZE_BITS-1:0] offset;
    logic [3:0]           rate_idx;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_OUT  = 2'd2
  } back_state_e;

  // MPEG-1 layer III bitrates in kbps
  function automatic logic [KBPS_W-1:0] kbps_lookup(input logic [3:0] idx);
    logic [KBPS_W-1:0] r;
    case (idx)
      4'd1:    r = 9'd32;
      4'd2:    r = 9'd40;
      4'd3:    r = 9'd48;
      4'd4:    r = 9'd56;
      4'd5:    r = 9'd64;
      4'd6:    r = 9'd80;
      4'd7:    r = 9'd96;
      4'd8:    r = 9'd112;
      4'd9:    r = 9'd128;
      4'd10:   r = 9'd160;
      4'd11:   r = 9'd192;
      4'd12:   r = 9'd224;
      4'd13:   r = 9'd256;
      4'd14:   r = 9'd320;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/mfsd_front.sv =====
// ----------------------------------------------------------------------------
// mfsd_front
// Byte scanner: keeps the three-byte window and position, classifies events.
// ----------------------------------------------------------------------------
module mfsd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  first_of_file_i,
  input  logic                  last_of_file_i,
  output logic                  push_o,
  output mfsd_pkg::job_t        job_o
);

  logic [23:0]                     window_q, window_d;
  logic [mfsd_pkg::SIZE_BITS-1:0]  pos_q, pos_d;
  logic                            done_q, done_d;

  logic [23:0]                     win_eff;
  logic [mfsd_pkg::SIZE_BITS-1:0]  pos_eff;
  logic                            done_eff;
  logic                            hit;

  always_comb begin
    win_eff  = first_of_file_i ? 24'd0 : window_q;
    pos_eff  = first_of_file_i ? '0 : pos_q;
    done_eff = first_of_file_i ? 1'b0 : done_q;

    hit = (win_eff[23:16] == mfsd_pkg::SYNC_BYTE) &&
          ((win_eff[15:8] & mfsd_pkg::SECOND_MASK) == mfsd_pkg::SECOND_MATCH);

    window_d = window_q;
    pos_d    = pos_q;
    done_d   = done_q;
    push_o   = 1'b0;

    job_o.offset   = pos_eff - mfsd_pkg::SIZE_BITS'(3);
    job_o.rate_idx = win_eff[7:4];
    if (hit) begin
      if (win_eff[7:4] == 4'd0 || win_eff[7:4] == 4'hF) begin
        job_o.status = mfsd_pkg::STATUS_BAD_RATE;
      end else begin
        job_o.status = mfsd_pkg::STATUS_OK;
      end
    end else begin
      job_o.status = mfsd_pkg::STATUS_NO_SYNC;
    end

    if (accept_i) begin
      window_d = win_eff;
      pos_d    = pos_eff;
      done_d   = done_eff;
      if (!done_eff) begin
        window_d = {win_eff[15:0], data_byte_i};
        pos_d    = pos_eff + mfsd_pkg::SIZE_BITS'(1);
        if (hit || last_of_file_i) begin
          push_o = 1'b1;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      pos_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      window_q <= window_d;
      pos_q    <= pos_d;
      done_q   <= done_d;
    end
  end

endmodule

// ===== hdl/mfsd_queue.sv =====
// ----------------------------------------------------------------------------
// mfsd_queue
// Two-entry event queue between scanner and divider.
// ----------------------------------------------------------------------------
module mfsd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mfsd_pkg::job_t job_i,
  input  logic           pop_i,
  output mfsd_pkg::job_t job_o,
  output logic           full_o,
  output logic           empty_o
);

  mfsd_pkg::job_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign job_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i && !full_o) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i && !empty_o) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i && !full_o, pop_i && !empty_o})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== hdl/mfsd_back.sv =====
// ----------------------------------------------------------------------------
// mfsd_back
// Result builder: bitrate lookup, bit-serial duration divide, output register.
// ----------------------------------------------------------------------------
module mfsd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mfsd_pkg::SIZE_BITS-1:0] file_size_i,
  input  logic                           job_valid_i,
  input  mfsd_pkg::job_t                 job_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mfsd_pkg::status_e              status_o,
  output logic [mfsd_pkg::OFFSET_W-1:0]  offset_o,
  output logic [mfsd_pkg::BPS_W-1:0]     bps_o,
  output logic [mfsd_pkg::DUR_W-1:0]     dur_o
);

  localparam int unsigned DB = mfsd_pkg::DIV_BITS;
  localparam int unsigned KW = mfsd_pkg::KBPS_W;

  mfsd_pkg::back_state_e state_q, state_d;

  logic [DB-1:0]               quo_q, quo_d;
  logic [KW-1:0]               rem_q, rem_d;
  logic [KW-1:0]               div_q, div_d;
  logic [mfsd_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  // control decoded from state
  logic load_job, div_step, div_last;

  logic [KW-1:0]                  kbps;
  logic [mfsd_pkg::SIZE_BITS-1:0] remain;
  logic [KW:0]                    trial;
  logic                           q_bit;
  logic [DB+mfsd_pkg::DUR_W-1:0]  quo_ext;
  logic [mfsd_pkg::SIZE_BITS+mfsd_pkg::OFFSET_W-1:0] off_ext;

  assign kbps     = mfsd_pkg::kbps_lookup(job_i.rate_idx);
  assign remain   = (file_size_i >= job_i.offset) ? (file_size_i - job_i.offset) : '0;
  assign trial    = {rem_q, quo_q[DB-1]};
  assign q_bit    = (trial >= {1'b0, div_q});
  assign div_last = (cnt_q == mfsd_pkg::CNT_W'(DB - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mfsd_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          state_d = (job_i.status == mfsd_pkg::STATUS_OK) ? mfsd_pkg::BK_DIV
                                                          : mfsd_pkg::BK_OUT;
        end
      end
      mfsd_pkg::BK_DIV: begin
        if (div_last) begin
          state_d = mfsd_pkg::BK_OUT;
        end
      end
      mfsd_pkg::BK_OUT: begin
        if (out_ready_i) begin
          state_d = mfsd_pkg::BK_IDLE;
        end
      end
      default: state_d = mfsd_pkg::BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    load_job    = 1'b0;
    div_step    = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      mfsd_pkg::BK_IDLE: load_job    = job_valid_i;
      mfsd_pkg::BK_DIV:  div_step    = 1'b1;
      mfsd_pkg::BK_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign pop_o = load_job;

  // divider datapath
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    div_d = div_q;
    cnt_d = cnt_q;
    if (load_job) begin
      quo_d = remain[mfsd_pkg::SIZE_BITS-1:mfsd_pkg::BPS_SHIFT];
      rem_d = '0;
      div_d = kbps;
      cnt_d = '0;
    end else if (div_step) begin
      rem_d = q_bit ? KW'(trial - {1'b0, div_q}) : trial[KW-1:0];
      quo_d = {quo_q[DB-2:0], q_bit};
      cnt_d = cnt_q + mfsd_pkg::CNT_W'(1);
    end
  end

  // final quotient includes the bit produced by the last step
  assign quo_ext = {{mfsd_pkg::DUR_W{1'b0}}, quo_d};
  assign off_ext = {{mfsd_pkg::OFFSET_W{1'b0}}, job_i.offset};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfsd_pkg::BK_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    if (load_job) begin
      status_o <= job_i.status;
      offset_o <= (job_i.status == mfsd_pkg::STATUS_NO_SYNC) ? '0
                                                             : off_ext[mfsd_pkg::OFFSET_W-1:0];
      bps_o    <= (job_i.status == mfsd_pkg::STATUS_OK)
                  ? mfsd_pkg::BPS_W'({kbps, {mfsd_pkg::BPS_SHIFT{1'b0}}}) : '0;
      dur_o    <= '0;
    end else if (div_step && div_last) begin
      dur_o <= quo_ext[mfsd_pkg::DUR_W-1:0] + mfsd_pkg::DUR_W'(1);
    end
  end

  // quotient of (remain >> 7) / kbps needs a nonzero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mfsd_pkg::BK_DIV |-> div_q != '0)
    else $error("divide with zero divisor");

  // partial remainder stays below divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mfsd_pkg::BK_DIV |-> rem_q < div_q)
    else $error("partial remainder out of range");

  // divide runs exactly DIV_BITS steps before presenting a result
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfsd_pkg::BK_DIV && div_last) |=> state_q == mfsd_pkg::BK_OUT)
    else $error("divide did not finish on count");

  // result held stable while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(dur_o) && $stable(offset_o))
    else $error("result changed under stall");

endmodule

// ===== hdl/mp3_frame_sync_duration_unit.sv =====
// ----------------------------------------------------------------------------
// mp3_frame_sync_duration_unit
// Finds the first frame header in a byte stream, reports bitrate and duration.
// ----------------------------------------------------------------------------
// Throughput: one byte word per cycle; s_axis_tready drops only while the
//   two-entry event queue is full, i.e. when events back up behind the divider or the sink.
// Result path: a header result goes through the event queue, the bitrate lookup
//   and the one-bit-per-cycle divider before its output register;
//   no-sync and bad-rate results skip the divider.
// Reset: async active low; clears window, position, queue and divider FSM.
module mp3_frame_sync_duration_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // file_size register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] first_of_file
  input  logic        s_axis_tlast,   // last_of_file
  // result out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] header_offset, [47:32] bytes_per_second,
                                      // [68:48] duration_seconds, [71:69] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic [31:0]                    file_size_q;
  logic [mfsd_pkg::SIZE_BITS+31:0] fs_ext;
  logic [mfsd_pkg::SIZE_BITS-1:0] file_size;

  logic                           in_accept;
  logic                           push;
  mfsd_pkg::job_t                 front_job;
  mfsd_pkg::job_t                 queue_job;
  logic                           q_full, q_empty, pop;

  mfsd_pkg::status_e              status;
  logic [mfsd_pkg::OFFSET_W-1:0]  offset;
  logic [mfsd_pkg::BPS_W-1:0]     bps;
  logic [mfsd_pkg::DUR_W-1:0]     dur;

  // register is to be written only while idle; the block does not enforce this, so it is always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
    end else if (cfg_valid_i) begin
      file_size_q <= cfg_data_i;
    end
  end

  // low SIZE_BITS of the file size, zero extended when wider than 32
  assign fs_ext    = {{mfsd_pkg::SIZE_BITS{1'b0}}, file_size_q};
  assign file_size = fs_ext[mfsd_pkg::SIZE_BITS-1:0];

  // front stalls only when the event queue is full
  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  mfsd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .data_byte_i     (s_axis_tdata),
    .first_of_file_i (s_axis_tuser[0]),
    .last_of_file_i  (s_axis_tlast),
    .push_o          (push),
    .job_o           (front_job)
  );

  mfsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .job_o   (queue_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mfsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .file_size_i (file_size),
    .job_valid_i (!q_empty),
    .job_i       (queue_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .offset_o    (offset),
    .bps_o       (bps),
    .dur_o       (dur)
  );

  assign m_axis_tdata = {3'b000, dur, bps, offset};
  assign m_axis_tuser = status;

endmodule
